### src/tes_pkg.sv
// Shared types and constants for the two-ended shared stack.
// Depends on nothing; used by the interfaces, the top level and the testbench.
`default_nettype none

package tes_pkg;

    localparam int DEPTH    = 256;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int WORD_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 8;
    localparam int COUNT_W  = 9;
    localparam int CAP_W    = 9;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_A = 3'd0,
        FN_PUSH_B = 3'd1,
        FN_POP_A  = 3'd2,
        FN_POP_B  = 3'd3,
        FN_PEEK_A = 3'd4,
        FN_PEEK_B = 3'd5,
        FN_CLEAR  = 3'd6,
        FN_SEARCH = 3'd7
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

endpackage

`default_nettype wire

### src/tes_if.sv
// Valid/ready channel interfaces: request, response and configuration write.
// Depends on tes_pkg for field widths and code types.
`default_nettype none

interface tes_req_if;
    logic                                valid;
    logic                                ready;
    tes_pkg::func_t                      func;
    logic signed [tes_pkg::WORD_W-1:0]   value;

    modport source (output valid, func, value, input ready);
    modport sink   (input valid, func, value, output ready);
endinterface

interface tes_rsp_if;
    logic                                valid;
    logic                                ready;
    tes_pkg::status_t                    status;
    logic signed [tes_pkg::WORD_W-1:0]   data;
    logic        [tes_pkg::FOUND_W-1:0]  found_index;
    logic        [tes_pkg::COUNT_W-1:0]  count_a_out;
    logic        [tes_pkg::COUNT_W-1:0]  count_b_out;

    modport source (output valid, status, data, found_index, count_a_out, count_b_out,
                    input ready);
    modport sink   (input valid, status, data, found_index, count_a_out, count_b_out,
                    output ready);
endinterface

interface tes_cfg_if;
    logic                                valid;
    logic                                ready;
    logic        [tes_pkg::CAP_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### src/tes_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module tes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/two_ended_shared_stack.sv
// Two stacks in one word store: A grows up from entry 0, B down from capacity-1.
// Depends on tes_pkg, the tes_*_if interfaces and tes_ram.
//
//  channel | modport | handshake    | payload
//  --------+---------+--------------+--------------------------------------------
//  cfg     | sink    | valid/ready  | data (capacity, 9 bits)
//  req     | sink    | valid/ready  | func, value
//  rsp     | source  | valid/ready  | status, data, found_index, count_a_out/b_out
//
// One item at a time through a small sequencer around one RAM port pair.
// Push and clear run through EXEC and DONE; pop and peek add a READ state
// (one RAM read). Search: n entries compared one per cycle by the
// single compare unit, n up to capacity. A stalled response holds the result
// in the output register; the next request is taken once it is loaded.
// Reset empties both stacks and clears one valid flop per entry, so an unwritten
// entry reads as zero without a clearing pass.
`default_nettype none

module two_ended_shared_stack (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tes_cfg_if.sink       cfg,
    tes_req_if.sink       req,
    tes_rsp_if.source     rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SRCH,
        S_DONE
    } state_t;

    state_t                              state_reg, state_next;
    tes_pkg::func_t                      func_reg, func_next;
    logic        [tes_pkg::WORD_W-1:0]   key_reg, key_next;
    logic        [tes_pkg::CAP_W-1:0]    cap_reg, cap_next;
    logic        [tes_pkg::CNT_W-1:0]    count_a_reg, count_a_next;
    logic        [tes_pkg::CNT_W-1:0]    count_b_reg, count_b_next;
    logic        [tes_pkg::ADDR_W-1:0]   idx_reg, idx_next;
    logic        [tes_pkg::DEPTH-1:0]    valid_reg, valid_next;
    logic                                valid_rd_reg, valid_rd_next;
    tes_pkg::status_t                    res_status_reg, res_status_next;
    logic        [tes_pkg::WORD_W-1:0]   res_data_reg, res_data_next;
    logic        [tes_pkg::ADDR_W-1:0]   res_found_reg, res_found_next;
    logic                                out_valid_reg, out_valid_next;
    tes_pkg::status_t                    out_status_reg, out_status_next;
    logic        [tes_pkg::WORD_W-1:0]   out_data_reg, out_data_next;
    logic        [tes_pkg::FOUND_W-1:0]  out_found_reg, out_found_next;
    logic        [tes_pkg::COUNT_W-1:0]  out_count_a_reg, out_count_a_next;
    logic        [tes_pkg::COUNT_W-1:0]  out_count_b_reg, out_count_b_next;

    logic        [tes_pkg::CNT_W-1:0]    eff_cap;
    logic        [tes_pkg::CNT_W:0]      sum_ab;
    logic                                full;
    logic        [tes_pkg::CNT_W-1:0]    idx_inc;
    logic        [tes_pkg::CNT_W-1:0]    addr_wide;
    logic        [tes_pkg::WORD_W-1:0]   word;

    logic                                ram_we;
    logic        [tes_pkg::ADDR_W-1:0]   ram_waddr;
    logic                                ram_re;
    logic        [tes_pkg::ADDR_W-1:0]   ram_raddr;
    logic        [tes_pkg::WORD_W-1:0]   ram_rdata;

    tes_ram #(
        .WIDTH (tes_pkg::WORD_W),
        .DEPTH (tes_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (key_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Zero capacity acts as one entry, anything above the store as the full store.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = tes_pkg::CNT_W'(1);
        end
        else if (32'(cap_reg) > 32'(tes_pkg::DEPTH))
        begin
            eff_cap = tes_pkg::CNT_W'(tes_pkg::DEPTH);
        end
        else
        begin
            eff_cap = tes_pkg::CNT_W'(cap_reg);
        end
    end

    assign sum_ab  = {1'b0, count_a_reg} + {1'b0, count_b_reg};
    assign full    = sum_ab >= {1'b0, eff_cap};
    assign idx_inc = tes_pkg::CNT_W'(idx_reg) + tes_pkg::CNT_W'(1);
    assign word    = valid_rd_reg ? ram_rdata : '0;

    assign req.ready       = (state_reg == S_IDLE);
    assign cfg.ready       = 1'b1;
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.data        = out_data_reg;
    assign rsp.found_index = out_found_reg;
    assign rsp.count_a_out = out_count_a_reg;
    assign rsp.count_b_out = out_count_b_reg;

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        key_next         = key_reg;
        cap_next         = cap_reg;
        count_a_next     = count_a_reg;
        count_b_next     = count_b_reg;
        idx_next         = idx_reg;
        valid_next       = valid_reg;
        valid_rd_next    = valid_rd_reg;
        res_status_next  = res_status_reg;
        res_data_next    = res_data_reg;
        res_found_next   = res_found_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_data_next    = out_data_reg;
        out_found_next   = out_found_reg;
        out_count_a_next = out_count_a_reg;
        out_count_b_next = out_count_b_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_re           = 1'b0;
        ram_raddr        = '0;
        addr_wide        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next  = req.func;
                    key_next   = req.value;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_status_next = tes_pkg::ST_OK;
                res_data_next   = '0;
                res_found_next  = '0;
                state_next      = S_DONE;
                case (func_reg)
                    tes_pkg::FN_PUSH_A, tes_pkg::FN_PUSH_B:
                    begin
                        if (full)
                        begin
                            res_status_next = tes_pkg::ST_FULL;
                        end
                        else
                        begin
                            if (func_reg == tes_pkg::FN_PUSH_A)
                            begin
                                addr_wide    = count_a_reg;
                                count_a_next = count_a_reg + tes_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                addr_wide    = eff_cap - tes_pkg::CNT_W'(1) - count_b_reg;
                                count_b_next = count_b_reg + tes_pkg::CNT_W'(1);
                            end
                            ram_we                = 1'b1;
                            ram_waddr             = addr_wide[tes_pkg::ADDR_W-1:0];
                            valid_next[ram_waddr] = 1'b1;
                        end
                    end
                    tes_pkg::FN_POP_A, tes_pkg::FN_PEEK_A:
                    begin
                        if (count_a_reg == '0)
                        begin
                            res_status_next = tes_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            addr_wide  = count_a_reg - tes_pkg::CNT_W'(1);
                            ram_re     = 1'b1;
                            ram_raddr  = addr_wide[tes_pkg::ADDR_W-1:0];
                            state_next = S_READ;
                        end
                    end
                    tes_pkg::FN_POP_B, tes_pkg::FN_PEEK_B:
                    begin
                        if (count_b_reg == '0)
                        begin
                            res_status_next = tes_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            addr_wide  = eff_cap - count_b_reg;
                            ram_re     = 1'b1;
                            ram_raddr  = addr_wide[tes_pkg::ADDR_W-1:0];
                            state_next = S_READ;
                        end
                    end
                    tes_pkg::FN_CLEAR:
                    begin
                        count_a_next = '0;
                        count_b_next = '0;
                    end
                    default:
                    begin
                        // search: prime the read of entry 0
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        idx_next   = '0;
                        state_next = S_SRCH;
                    end
                endcase
                if (ram_re)
                begin
                    valid_rd_next = valid_reg[ram_raddr];
                end
            end

            S_READ:
            begin
                res_data_next = word;
                if (func_reg == tes_pkg::FN_POP_A)
                begin
                    count_a_next = count_a_reg - tes_pkg::CNT_W'(1);
                end
                if (func_reg == tes_pkg::FN_POP_B)
                begin
                    count_b_next = count_b_reg - tes_pkg::CNT_W'(1);
                end
                state_next = S_DONE;
            end

            S_SRCH:
            begin
                // idx_reg names the entry whose data is on the read port now
                if (word == key_reg)
                begin
                    res_status_next = tes_pkg::ST_OK;
                    res_found_next  = idx_reg;
                    state_next      = S_DONE;
                end
                else if (idx_inc >= eff_cap)
                begin
                    res_status_next = tes_pkg::ST_MISS;
                    res_found_next  = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = idx_inc[tes_pkg::ADDR_W-1:0];
                    valid_rd_next = valid_reg[ram_raddr];
                    idx_next      = idx_inc[tes_pkg::ADDR_W-1:0];
                end
            end

            S_DONE:
            begin
                // load the output register once the previous result is gone
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_data_next    = res_data_reg;
                    out_found_next   = tes_pkg::FOUND_W'(res_found_reg);
                    out_count_a_next = tes_pkg::COUNT_W'(count_a_reg);
                    out_count_b_next = tes_pkg::COUNT_W'(count_b_reg);
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // capacity write empties both stacks, store kept
        if (cfg.valid)
        begin
            cap_next     = cfg.data;
            count_a_next = '0;
            count_b_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            func_reg        <= tes_pkg::FN_PUSH_A;
            key_reg         <= '0;
            cap_reg         <= tes_pkg::CAP_W'(tes_pkg::DEPTH);
            count_a_reg     <= '0;
            count_b_reg     <= '0;
            idx_reg         <= '0;
            valid_reg       <= '0;
            valid_rd_reg    <= 1'b0;
            res_status_reg  <= tes_pkg::ST_OK;
            res_data_reg    <= '0;
            res_found_reg   <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= tes_pkg::ST_OK;
            out_data_reg    <= '0;
            out_found_reg   <= '0;
            out_count_a_reg <= '0;
            out_count_b_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            func_reg        <= func_next;
            key_reg         <= key_next;
            cap_reg         <= cap_next;
            count_a_reg     <= count_a_next;
            count_b_reg     <= count_b_next;
            idx_reg         <= idx_next;
            valid_reg       <= valid_next;
            valid_rd_reg    <= valid_rd_next;
            res_status_reg  <= res_status_next;
            res_data_reg    <= res_data_next;
            res_found_reg   <= res_found_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_data_reg    <= out_data_next;
            out_found_reg   <= out_found_next;
            out_count_a_reg <= out_count_a_next;
            out_count_b_reg <= out_count_b_next;
        end
    end

    // the two stacks never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        sum_ab <= {1'b0, eff_cap})
        else $error("stack counts exceed capacity");

    // search pointer stays below the effective capacity
    a_srch_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH) |-> (tes_pkg::CNT_W'(idx_reg) < eff_cap))
        else $error("search index beyond capacity");

    // a transfer in makes the block busy on the next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while busy");

    // a full refusal only happens with the stacks actually full
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && !full) |=> (res_status_reg != tes_pkg::ST_FULL))
        else $error("push refused with room left");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for two_ended_shared_stack: pushes, pops, peeks, clears and
// searches on both stacks, checked against an in-bench shadow of the store and counts.
// Depends on tes_pkg, the tes_*_if interfaces and the two_ended_shared_stack RTL.

module testbench;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        tes_pkg::status_t                   status;
        logic [tes_pkg::WORD_W-1:0]         data;
        logic [tes_pkg::FOUND_W-1:0]        found_index;
        logic [tes_pkg::COUNT_W-1:0]        count_a;
        logic [tes_pkg::COUNT_W-1:0]        count_b;
    } stack_result_t;

    logic clk;
    logic rst_n;

    tes_cfg_if cfg_ch ();
    tes_req_if req_ch ();
    tes_rsp_if rsp_ch ();

    two_ended_shared_stack i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow of the block state
    logic [tes_pkg::WORD_W-1:0] shadow_store [tes_pkg::DEPTH];
    int unsigned       fill_a;
    int unsigned       fill_b;
    int unsigned       live_cap;

    stack_result_t     awaited_rsp [$];
    stack_result_t     head_rsp;
    stack_result_t     seen_rsp;
    int                mismatch_count;
    int                cycle_count;
    int                hold_cycles;
    bit                req_gaps;
    bit                rsp_gaps;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic stack_result_t apply_stack_op(tes_pkg::func_t op,
                                                     logic [tes_pkg::WORD_W-1:0] word);
        stack_result_t r;
        bit            full;
        int unsigned   idx;
        full          = (fill_a + fill_b) >= live_cap;
        r.status      = tes_pkg::ST_OK;
        r.data        = '0;
        r.found_index = '0;
        case (op)
            tes_pkg::FN_PUSH_A:
            begin
                if (full)
                    r.status = tes_pkg::ST_FULL;
                else
                begin
                    shadow_store[fill_a] = word;
                    fill_a++;
                end
            end
            tes_pkg::FN_PUSH_B:
            begin
                if (full)
                    r.status = tes_pkg::ST_FULL;
                else
                begin
                    shadow_store[live_cap - 1 - fill_b] = word;
                    fill_b++;
                end
            end
            tes_pkg::FN_POP_A, tes_pkg::FN_PEEK_A:
            begin
                if (fill_a == 0)
                    r.status = tes_pkg::ST_EMPTY;
                else
                begin
                    r.data = shadow_store[fill_a - 1];
                    if (op == tes_pkg::FN_POP_A)
                        fill_a--;
                end
            end
            tes_pkg::FN_POP_B, tes_pkg::FN_PEEK_B:
            begin
                if (fill_b == 0)
                    r.status = tes_pkg::ST_EMPTY;
                else
                begin
                    r.data = shadow_store[live_cap - fill_b];
                    if (op == tes_pkg::FN_POP_B)
                        fill_b--;
                end
            end
            tes_pkg::FN_CLEAR:
            begin
                fill_a = 0;
                fill_b = 0;
            end
            default:
            begin
                // lowest matching entry over the whole capacity, stacked or not
                idx = 0;
                while (idx < live_cap && shadow_store[idx] != word)
                    idx++;
                if (idx < live_cap)
                    r.found_index = tes_pkg::FOUND_W'(idx);
                else
                    r.status = tes_pkg::ST_MISS;
            end
        endcase
        r.count_a = tes_pkg::COUNT_W'(fill_a);
        r.count_b = tes_pkg::COUNT_W'(fill_b);
        return r;
    endfunction

    task automatic send_op(tes_pkg::func_t op, logic [tes_pkg::WORD_W-1:0] word);
        @(negedge clk);
        while (req_gaps && $urandom_range(99) < 33)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= op;
        req_ch.value <= word;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        awaited_rsp.push_back(apply_stack_op(op, word));
    endtask

    // write only with the request side quiet and every result back
    task automatic write_capacity(logic [tes_pkg::CAP_W-1:0] cap);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= cap;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        live_cap = (cap == 0) ? 1 : ((cap > tes_pkg::DEPTH) ? tes_pkg::DEPTH : cap);
        fill_a   = 0;
        fill_b   = 0;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_mix(int n_items);
        int                         roll;
        tes_pkg::func_t             op;
        logic [tes_pkg::WORD_W-1:0] word;
        for (int k = 0; k < n_items; k++)
        begin
            roll = $urandom_range(99);
            if (roll < 22)
                op = tes_pkg::FN_PUSH_A;
            else if (roll < 44)
                op = tes_pkg::FN_PUSH_B;
            else if (roll < 58)
                op = tes_pkg::FN_POP_A;
            else if (roll < 72)
                op = tes_pkg::FN_POP_B;
            else if (roll < 79)
                op = tes_pkg::FN_PEEK_A;
            else if (roll < 86)
                op = tes_pkg::FN_PEEK_B;
            else if (roll < 88)
                op = tes_pkg::FN_CLEAR;
            else
                op = tes_pkg::FN_SEARCH;
            // bias search keys toward words already in the store
            if (op == tes_pkg::FN_SEARCH && $urandom_range(2) != 0)
                word = shadow_store[$urandom_range(live_cap - 1)];
            else if ($urandom_range(3) == 0)
                word = $urandom_range(15);
            else
                word = $urandom;
            send_op(op, word);
        end
    endtask

    task automatic test_directed();
        send_op(tes_pkg::FN_POP_A, 32'd0);
        send_op(tes_pkg::FN_POP_B, 32'd0);
        send_op(tes_pkg::FN_PEEK_A, 32'd0);
        send_op(tes_pkg::FN_PEEK_B, 32'd0);
        send_op(tes_pkg::FN_SEARCH, 32'd0);
        send_op(tes_pkg::FN_SEARCH, 32'h7FFF_FFFF);
        send_op(tes_pkg::FN_PUSH_A, 32'h8000_0000);
        send_op(tes_pkg::FN_PUSH_A, 32'h7FFF_FFFF);
        send_op(tes_pkg::FN_PUSH_B, 32'hFFFF_FFFF);
        send_op(tes_pkg::FN_PEEK_A, 32'd0);
        send_op(tes_pkg::FN_PEEK_B, 32'd0);
        send_op(tes_pkg::FN_SEARCH, 32'hFFFF_FFFF);
        send_op(tes_pkg::FN_POP_A, 32'd0);
        send_op(tes_pkg::FN_POP_B, 32'd0);
        send_op(tes_pkg::FN_CLEAR, 32'd0);
        send_op(tes_pkg::FN_PEEK_A, 32'd0);
        // clear keeps the store contents
        send_op(tes_pkg::FN_SEARCH, 32'h8000_0000);
        // zero capacity acts as a single entry
        write_capacity(9'd0);
        send_op(tes_pkg::FN_PUSH_A, 32'd5);
        send_op(tes_pkg::FN_PUSH_B, 32'd6);
        send_op(tes_pkg::FN_PEEK_B, 32'd0);
        send_op(tes_pkg::FN_POP_A, 32'd0);
        send_op(tes_pkg::FN_PUSH_B, 32'd6);
        send_op(tes_pkg::FN_PEEK_B, 32'd0);
        send_op(tes_pkg::FN_SEARCH, 32'h7FFF_FFFF);
        // oversized capacity clamps to the full store; the write empties both stacks
        write_capacity(9'h1FF);
        send_op(tes_pkg::FN_SEARCH, 32'h7FFF_FFFF);
        send_op(tes_pkg::FN_PEEK_B, 32'd0);
    endtask

    task automatic test_fill_to_full();
        logic [tes_pkg::CAP_W-1:0] caps [2];
        caps[0] = 9'd2;
        caps[1] = 9'd256;
        foreach (caps[c])
        begin
            write_capacity(caps[c]);
            while (fill_a + fill_b < live_cap)
                send_op($urandom_range(1) ? tes_pkg::FN_PUSH_B : tes_pkg::FN_PUSH_A,
                        $urandom);
            send_op(tes_pkg::FN_PUSH_A, $urandom);
            send_op(tes_pkg::FN_PUSH_B, $urandom);
            send_op(tes_pkg::FN_SEARCH, $urandom);
            send_op(tes_pkg::FN_PEEK_A, 32'd0);
            send_op(tes_pkg::FN_PEEK_B, 32'd0);
            send_op(tes_pkg::FN_POP_A, 32'd0);
            send_op(tes_pkg::FN_POP_B, 32'd0);
        end
    endtask

    task automatic test_random_mix();
        for (int p = 0; p < 3; p++)
        begin
            write_capacity(tes_pkg::CAP_W'($urandom_range(16, 1)));
            run_mix(80);
        end
        write_capacity(9'd64);
        run_mix(80);
        write_capacity(9'd256);
        run_mix(80);
        write_capacity(tes_pkg::CAP_W'($urandom_range(510, 257)));
        run_mix(60);
    endtask

    task automatic test_no_gaps();
        write_capacity(9'd8);
        req_gaps = 1'b0;
        rsp_gaps = 1'b0;
        run_mix(150);
        req_gaps = 1'b1;
        rsp_gaps = 1'b1;
    endtask

    task automatic test_output_stall();
        write_capacity(9'd16);
        req_gaps = 1'b0;
        send_op(tes_pkg::FN_PUSH_A, $urandom);
        // hold the response side while requests keep coming
        hold_cycles = 300;
        run_mix(40);
        req_gaps = 1'b1;
    endtask

    // response side: random stalls, plus an optional long hold-off
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else
                rsp_ch.ready <= !(rsp_gaps && $urandom_range(99) < 33);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            seen_rsp = '{status: rsp_ch.status, data: rsp_ch.data,
                         found_index: rsp_ch.found_index,
                         count_a: rsp_ch.count_a_out, count_b: rsp_ch.count_b_out};
            if (awaited_rsp.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result st=%0d data=%h idx=%0d a=%0d b=%0d",
                             $realtime, seen_rsp.status, seen_rsp.data,
                             seen_rsp.found_index, seen_rsp.count_a, seen_rsp.count_b);
            end
            else
            begin
                head_rsp = awaited_rsp.pop_front();
                if (seen_rsp !== head_rsp)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: result mismatch exp st=%0d data=%h idx=%0d a=%0d b=%0d",
                                  " got st=%0d data=%h idx=%0d a=%0d b=%0d"},
                                 $realtime, head_rsp.status, head_rsp.data,
                                 head_rsp.found_index, head_rsp.count_a, head_rsp.count_b,
                                 seen_rsp.status, seen_rsp.data, seen_rsp.found_index,
                                 seen_rsp.count_a, seen_rsp.count_b);
                end
            end
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.func    = tes_pkg::FN_PUSH_A;
        req_ch.value   = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        hold_cycles    = 0;
        req_gaps       = 1'b1;
        rsp_gaps       = 1'b1;
        fill_a         = 0;
        fill_b         = 0;
        live_cap       = tes_pkg::DEPTH;
        foreach (shadow_store[i])
            shadow_store[i] = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_fill_to_full();
        test_random_mix();
        test_no_gaps();
        test_output_stall();

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
